// File: hw/rtl/tprf_pkg.sv
// Shared types and constants for the TCP port rule filter.
// Used by the header parser, the rule cells and the top level; no dependencies.
package tprf_pkg;

    localparam logic OP_RULE_WRITE = 1'b0;
    localparam logic OP_FRAME_BYTE = 1'b1;

    localparam logic [2:0] VERDICT_DROP = 3'd1;

    // Byte offsets inside an untagged Ethernet frame with a 20-byte IPv4 header.
    localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
    localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
    localparam logic [5:0] POS_IP_PROTO  = 6'd23;
    localparam logic [5:0] POS_DPORT_HI  = 6'd36;
    localparam logic [5:0] POS_DPORT_LO  = 6'd37;
    localparam logic [5:0] POS_MIN_LAST  = 6'd53;
    localparam logic [5:0] POS_SATURATE  = 6'd63;

    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP  = 8'h06;

    typedef struct packed {
        logic        operation;
        logic [6:0]  rule_index;
        logic [15:0] rule_port;
        logic [2:0]  rule_action;
        logic [7:0]  frame_byte;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       matched;
        logic [6:0] matched_index;
    } out_item_t;

    // Rule write broadcast to every cell.
    typedef struct packed {
        logic        en;
        logic [6:0]  index;
        logic [15:0] port;
        logic [2:0]  action;
    } rule_wr_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic        matched;
        logic [2:0]  verdict;
        logic [6:0]  index;
        logic [15:0] port;
    } token_t;

endpackage

// File: hw/rtl/tcp_port_rule_filter_core.sv
// Top level of the TCP destination port rule filter.
// Depends on tprf_pkg, tprf_parser and tprf_cell.
//
// Usage:
//   The s_ channel carries items of type in_item_t. An item with operation
//   OP_RULE_WRITE stores (rule_port, rule_action) into slot rule_index; slots
//   at or beyond MAX_RULES are ignored. An item with operation OP_FRAME_BYTE
//   carries one frame byte in wire order; last_byte marks the frame's end.
//   Only a last byte produces a result item on the m_ channel (out_item_t).
//   Rule writes and ordinary bytes are taken one per cycle with no result.
//   A last byte launches a search token down a row of MAX_RULES cells, one
//   cell per cycle; each cell registers the token, and the result register
//   takes the item from the last cell, so the row length sets the frame-end
//   latency. While the token is in flight s_ready is low. s_ready is also
//   low while a finished result waits and m_ready is low, so a stalled
//   receiver holds the block; the result register keeps its item until taken.
//   Reset (aresetn low, synchronous) empties every rule slot, clears the
//   header parser and drops any search or pending result.
module tcp_port_rule_filter_core
    import tprf_pkg::*;
#(
    parameter int MAX_RULES = 128
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      s_fire;
    logic      byte_en;
    logic      search_start;
    logic [15:0] frame_port;
    rule_wr_t  wr;
    token_t    chain [0:MAX_RULES];
    token_t    tok_exit;

    logic      busy_reg, busy_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    // The search must not see rule writes, so the input waits while it runs.
    assign s_ready      = !busy_reg && (!m_valid_reg || m_ready);
    assign s_fire       = s_valid && s_ready;
    assign byte_en      = s_fire && (s_item.operation == OP_FRAME_BYTE);
    assign search_start = byte_en && s_item.last_byte;

    assign wr.en     = s_fire && (s_item.operation == OP_RULE_WRITE);
    assign wr.index  = s_item.rule_index;
    assign wr.port   = s_item.rule_port;
    assign wr.action = s_item.rule_action;

    tprf_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .frame_byte (s_item.frame_byte),
        .last_byte  (s_item.last_byte),
        .frame_port (frame_port)
    );

    // The token enters with the default verdict and picks up the first hit.
    always_comb begin
        chain[0].valid   = search_start;
        chain[0].done    = 1'b0;
        chain[0].matched = 1'b0;
        chain[0].verdict = VERDICT_DROP;
        chain[0].index   = '0;
        chain[0].port    = frame_port;
    end

    for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
        tprf_cell #(
            .CellIndex (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr      (wr),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign tok_exit = chain[MAX_RULES];

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (search_start) begin
            busy_next = 1'b1;
        end else if (tok_exit.valid) begin
            busy_next                 = 1'b0;
            m_valid_next              = 1'b1;
            m_item_next.verdict       = tok_exit.verdict;
            m_item_next.matched       = tok_exit.matched;
            m_item_next.matched_index = tok_exit.index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: hw/rtl/tprf_parser.sv
// Frame header parser: tracks byte position and extracts the TCP destination port.
// Depends on tprf_pkg.
module tprf_parser
    import tprf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic [15:0] frame_port
);

    logic [5:0]  pos_reg, pos_next;
    logic        ipv4_reg, ipv4_next;
    logic        tcp_reg, tcp_next;
    logic [15:0] dport_reg, dport_next;

    // Port as seen when the current byte is the last one; fields never change on it.
    assign frame_port = (pos_reg >= POS_MIN_LAST && ipv4_reg && tcp_reg) ? dport_reg : 16'd0;

    always_comb begin
        pos_next   = pos_reg;
        ipv4_next  = ipv4_reg;
        tcp_next   = tcp_reg;
        dport_next = dport_reg;
        if (byte_en) begin
            case (pos_reg)
                POS_ETYPE_HI: ipv4_next = (frame_byte == ETYPE_IPV4_HI);
                POS_ETYPE_LO: ipv4_next = ipv4_reg && (frame_byte == ETYPE_IPV4_LO);
                POS_IP_PROTO: tcp_next = (frame_byte == IP_PROTO_TCP);
                POS_DPORT_HI: dport_next = {frame_byte, dport_reg[7:0]};
                POS_DPORT_LO: dport_next = {dport_reg[15:8], frame_byte};
                default: ;
            endcase
            if (pos_reg != POS_SATURATE) begin
                pos_next = pos_reg + 6'd1;
            end
            if (last_byte) begin
                pos_next   = '0;
                ipv4_next  = 1'b0;
                tcp_next   = 1'b0;
                dport_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ipv4_reg  <= 1'b0;
            tcp_reg   <= 1'b0;
            dport_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            ipv4_reg  <= ipv4_next;
            tcp_reg   <= tcp_next;
            dport_reg <= dport_next;
        end
    end

endmodule

// File: hw/rtl/tprf_cell.sv
// One rule cell: holds one rule slot and checks the passing search token against it.
// Depends on tprf_pkg.
module tprf_cell
    import tprf_pkg::*;
#(
    parameter int CellIndex = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  rule_wr_t wr,
    input  token_t   tok_in,
    output token_t   tok_out
);

    localparam logic [6:0] IdxLow = 7'(CellIndex);

    logic [15:0] port_reg, port_next;
    logic [2:0]  action_reg, action_next;
    token_t      tok_reg, tok_next;

    assign tok_out = tok_reg;

    always_comb begin
        port_next   = port_reg;
        action_next = action_reg;
        if (wr.en && (int'(wr.index) == CellIndex)) begin
            port_next   = wr.port;
            action_next = wr.action;
        end
    end

    // An empty slot ends the list; otherwise an equal port ends the search with a hit.
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done) begin
            if (port_reg == 16'd0) begin
                tok_next.done = 1'b1;
            end else if (port_reg == tok_in.port) begin
                tok_next.done    = 1'b1;
                tok_next.matched = 1'b1;
                tok_next.verdict = action_reg;
                tok_next.index   = IdxLow;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_reg      <= '0;
            action_reg    <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            port_reg      <= port_next;
            action_reg    <= action_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.done    <= tok_next.done;
        tok_reg.matched <= tok_next.matched;
        tok_reg.verdict <= tok_next.verdict;
        tok_reg.index   <= tok_next.index;
        tok_reg.port    <= tok_next.port;
    end

endmodule

// File: verif/tcp_port_rule_filter_core_test.sv
// Self-checking testbench for tcp_port_rule_filter_core: rule writes and frame bytes go in,
// and each verdict that comes out is compared with a verdict predicted inside the bench.
// Depends on tprf_pkg and the tcp_port_rule_filter_core RTL only.
module tcp_port_rule_filter_core_test;
    import tprf_pkg::*;

    localparam int MAX_RULES    = 128;
    localparam int ITEM_TARGET  = 1800;
    localparam int MIN_VERDICTS = 24;
    // The longest correct wait without any handshake is one search through the rule row,
    // one full receiver stall and one full sender gap. The limit is several times larger.
    localparam int STALL_LIMIT  = 2000;

    // Frame shapes that the stimulus generator can build.
    typedef enum int {
        SHAPE_CLEAN,
        SHAPE_BAD_ETYPE_HI,
        SHAPE_BAD_ETYPE_LO,
        SHAPE_NOT_TCP,
        SHAPE_NOISE
    } frame_shape_t;

    // An item waiting to be sent. When hold is set, the driver does not present the item
    // until every expected verdict has come back.
    typedef struct packed {
        logic     hold;
        in_item_t item;
    } send_entry_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    tcp_port_rule_filter_core #(
        .MAX_RULES(MAX_RULES)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The driver takes items from this queue.
    send_entry_t send_queue[$];
    // Verdicts that are predicted but have not been received yet, oldest first.
    out_item_t   verdicts_due[$];

    int errors = 0;
    int sent_items = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int stall_cycles = 0;

    // The generator's own view of the rule ports. It is used only to pick ports that will
    // hit the table and slots for rule writes. Checking does not depend on it.
    logic [15:0] plan_ports[MAX_RULES];
    int planned_items = 0;
    int planned_frames = 0;

    // Predictor state. This is a copy of the rule table and of the header parser, and it
    // is updated only when the DUT accepts an item.
    logic [15:0] rule_port_mem[MAX_RULES];
    logic [2:0]  rule_act_mem[MAX_RULES];
    logic [5:0]  hdr_pos   = '0;
    logic        hdr_ipv4  = 1'b0;
    logic        hdr_tcp   = 1'b0;
    logic [15:0] hdr_dport = '0;

    initial begin
        for (int i = 0; i < MAX_RULES; i++) begin
            rule_port_mem[i] = '0;
            rule_act_mem[i]  = '0;
            plan_ports[i]    = '0;
        end
    end

    // This task applies one accepted item to the predictor. A rule write updates the
    // table. A frame byte moves the header parser on by one position, and the last byte
    // of a frame searches the table and queues the verdict that the DUT should return.
    task automatic absorb_item(input in_item_t it);
        logic [5:0]  pos;
        logic [15:0] port;
        out_item_t   res;
        logic        searching;
        if (it.operation == OP_RULE_WRITE) begin
            if (int'(it.rule_index) < MAX_RULES) begin
                rule_port_mem[it.rule_index] = it.rule_port;
                rule_act_mem[it.rule_index]  = it.rule_action;
            end
        end else begin
            pos = hdr_pos;
            case (pos)
                POS_ETYPE_HI: hdr_ipv4 = (it.frame_byte == ETYPE_IPV4_HI);
                POS_ETYPE_LO: hdr_ipv4 = hdr_ipv4 && (it.frame_byte == ETYPE_IPV4_LO);
                POS_IP_PROTO: hdr_tcp = (it.frame_byte == IP_PROTO_TCP);
                POS_DPORT_HI: hdr_dport[15:8] = it.frame_byte;
                POS_DPORT_LO: hdr_dport[7:0] = it.frame_byte;
                default: ;
            endcase
            // The position saturates, so bytes of a long frame past it change nothing.
            if (hdr_pos != POS_SATURATE) begin
                hdr_pos = hdr_pos + 6'd1;
            end
            if (it.last_byte) begin
                // The port counts only for a full-size IPv4/TCP frame. Port 0 never
                // matches, because a port of 0 in the table ends the search first.
                port = (pos >= POS_MIN_LAST && hdr_ipv4 && hdr_tcp) ? hdr_dport : 16'd0;
                res.verdict       = VERDICT_DROP;
                res.matched       = 1'b0;
                res.matched_index = '0;
                searching = 1'b1;
                for (int i = 0; i < MAX_RULES && searching; i++) begin
                    if (rule_port_mem[i] == 16'd0) begin
                        searching = 1'b0;
                    end else if (rule_port_mem[i] == port) begin
                        res.verdict       = rule_act_mem[i];
                        res.matched       = 1'b1;
                        res.matched_index = 7'(i);
                        searching = 1'b0;
                    end
                end
                verdicts_due.push_back(res);
                hdr_pos   = '0;
                hdr_ipv4  = 1'b0;
                hdr_tcp   = 1'b0;
                hdr_dport = '0;
            end
        end
    endtask

    // Idling is allowed only in some stretches of the run, and never near the end.
    function automatic bit idling_allowed();
        return send_queue.size() > 150 && (sent_items % 500) < 350;
    endfunction

    // Fields that the operation does not use get random values, so that every bit of
    // them still toggles.
    function automatic in_item_t random_item();
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        return junk[$bits(in_item_t)-1:0];
    endfunction

    task automatic queue_item(input in_item_t it, input logic hold);
        send_entry_t e;
        e.hold = hold;
        e.item = it;
        send_queue.push_back(e);
        planned_items++;
    endtask

    task automatic plan_rule(input int idx, input logic [15:0] port, input logic [2:0] act);
        in_item_t it;
        it = random_item();
        it.operation   = OP_RULE_WRITE;
        it.rule_index  = 7'(idx);
        it.rule_port   = port;
        it.rule_action = act;
        queue_item(it, 1'b0);
        if (idx < MAX_RULES) begin
            plan_ports[idx] = port;
        end
    endtask

    // This function returns the number of rules that a search can reach, that is, the
    // number of slots before the first port of 0.
    function automatic int list_len();
        for (int i = 0; i < MAX_RULES; i++) begin
            if (plan_ports[i] == 16'd0) begin
                return i;
            end
        end
        return MAX_RULES;
    endfunction

    // Most random rule writes land inside the live list or just after its end, so the
    // list stays long. A few writes of port 0 cut the list short. The small pool of ports
    // makes duplicates, so the first match has to win over a later one.
    task automatic plan_random_rule();
        int n;
        int idx;
        int r;
        logic [15:0] port;
        n   = list_len();
        idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (n < MAX_RULES) ? n : n - 1)
                                         : $urandom_range(0, MAX_RULES - 1);
        r = $urandom_range(0, 99);
        if (r < 4) begin
            port = 16'd0;
        end else if (r < 24) begin
            port = 16'($urandom_range(1, 8));
        end else if (r < 30) begin
            port = 16'hFFFF;
        end else begin
            port = 16'($urandom_range(1, 65535));
        end
        plan_rule(idx, port, 3'($urandom_range(0, 7)));
    endtask

    function automatic logic [15:0] pick_port();
        int n;
        int r;
        n = list_len();
        r = $urandom_range(0, 99);
        if (r < 65 && n > 0) begin
            return plan_ports[$urandom_range(0, n - 1)];
        end else if (r < 75) begin
            return plan_ports[$urandom_range(0, MAX_RULES - 1)];
        end else if (r < 80) begin
            return 16'd0;
        end
        return 16'($urandom);
    endfunction

    // This task queues one frame of len bytes with the given header shape and destination
    // port. When rule_odds is not zero, a rule write comes before each byte but the first
    // with a chance of 1 in rule_odds, which puts rule writes in the middle of the frame.
    task automatic plan_frame(input int len, input frame_shape_t shape,
                              input logic [15:0] port, input logic hold, input int rule_odds);
        logic [7:0] b;
        in_item_t   it;
        logic       first;
        first = hold;
        for (int k = 0; k < len; k++) begin
            if (rule_odds != 0 && k != 0 && $urandom_range(0, rule_odds - 1) == 0) begin
                plan_random_rule();
            end
            b = 8'($urandom);
            if (shape != SHAPE_NOISE) begin
                if (k == int'(POS_ETYPE_HI)) begin
                    b = ETYPE_IPV4_HI;
                    if (shape == SHAPE_BAD_ETYPE_HI) begin
                        b = ETYPE_IPV4_HI ^ 8'($urandom_range(1, 255));
                    end
                end else if (k == int'(POS_ETYPE_LO)) begin
                    b = ETYPE_IPV4_LO;
                    if (shape == SHAPE_BAD_ETYPE_LO) begin
                        b = ETYPE_IPV4_LO ^ 8'($urandom_range(1, 255));
                    end
                end else if (k == int'(POS_IP_PROTO)) begin
                    b = IP_PROTO_TCP;
                    if (shape == SHAPE_NOT_TCP) begin
                        b = IP_PROTO_TCP ^ 8'($urandom_range(1, 255));
                    end
                end else if (k == int'(POS_DPORT_HI)) begin
                    b = port[15:8];
                end else if (k == int'(POS_DPORT_LO)) begin
                    b = port[7:0];
                end
            end
            it = random_item();
            it.operation  = OP_FRAME_BYTE;
            it.frame_byte = b;
            it.last_byte  = (k == len - 1);
            queue_item(it, first);
            first = 1'b0;
        end
        planned_frames++;
    endtask

    // Driver. s_valid stays high with the same item until the item is accepted. Between
    // items, the driver may insert a random gap. It also waits before an item that is
    // marked hold until no verdict is outstanding.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_item(s_item);
                sent_items++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (send_queue.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (send_queue[0].hold && verdicts_due.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 18);
                    s_valid <= 1'b0;
                end else begin
                    s_item  <= send_queue[0].item;
                    s_valid <= 1'b1;
                    void'(send_queue.pop_front());
                end
            end
        end
    end

    // Monitor. It compares each accepted verdict with the oldest prediction and drops
    // m_ready in random bursts.
    always @(posedge aclk) begin : verdict_monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("m_item: verdict %0d arrived with no item expected", m_item.verdict);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_item.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, m_item.verdict);
                        errors++;
                    end
                    if (m_item.matched !== want.matched) begin
                        $error("matched: expected %0d, actual %0d", want.matched, m_item.matched);
                        errors++;
                    end
                    if (m_item.matched_index !== want.matched_index) begin
                        $error("matched_index: expected %0d, actual %0d",
                               want.matched_index, m_item.matched_index);
                        errors++;
                    end
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog. It ends the run when no handshake happens on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int roll;
        int len;
        frame_shape_t shape;
        // The whole stimulus is queued up front. The driver only starts after reset.

        // Directed part. The first frame meets an empty table and must be dropped.
        plan_frame(54, SHAPE_CLEAN, 16'd80, 1'b0, 0);
        plan_rule(0, 16'hFFFF, 3'd7);
        plan_rule(1, 16'd1, 3'd0);
        plan_rule(2, 16'd80, 3'd2);
        plan_rule(3, 16'd443, 3'd3);
        plan_rule(4, 16'd80, 3'd4);
        // These frames check the extreme ports, the aborted action, and that the first of
        // two rules with port 80 wins.
        plan_frame(54, SHAPE_CLEAN, 16'hFFFF, 1'b0, 0);
        plan_frame(60, SHAPE_CLEAN, 16'd1, 1'b0, 0);
        plan_frame(54, SHAPE_CLEAN, 16'd80, 1'b0, 0);
        // A long frame saturates the byte position.
        plan_frame(90, SHAPE_CLEAN, 16'd443, 1'b0, 0);
        // One byte short of the minimum length, and a frame of a single byte.
        plan_frame(53, SHAPE_CLEAN, 16'd80, 1'b0, 0);
        plan_frame(1, SHAPE_CLEAN, 16'd80, 1'b0, 0);
        // Frames whose headers are wrong.
        plan_frame(54, SHAPE_BAD_ETYPE_HI, 16'd80, 1'b0, 0);
        plan_frame(54, SHAPE_BAD_ETYPE_LO, 16'd80, 1'b0, 0);
        plan_frame(54, SHAPE_NOT_TCP, 16'd80, 1'b0, 0);
        // Port 0, a port that is not in the table, and rule writes inside a frame.
        plan_frame(54, SHAPE_CLEAN, 16'd0, 1'b0, 0);
        plan_frame(54, SHAPE_CLEAN, 16'd9999, 1'b0, 0);
        plan_frame(56, SHAPE_CLEAN, 16'd443, 1'b0, 4);

        // Every slot gets a rule, so the search runs through the whole row and the last
        // slot can match.
        for (int i = 0; i < MAX_RULES; i++) begin
            plan_rule(i, 16'(1000 + i), 3'(i % 8));
        end
        plan_frame(54, SHAPE_CLEAN, 16'(1000 + MAX_RULES - 1), 1'b1, 0);
        // A port of 0 in the middle of the table hides every rule after it.
        plan_rule(64, 16'd0, 3'd0);
        plan_frame(54, SHAPE_CLEAN, 16'd1100, 1'b0, 0);
        plan_rule(64, 16'd1064, 3'd5);

        // Random part. Most items are well-formed IPv4/TCP frames that carry ports from
        // the table. The rest are short frames, frames with broken headers, noise, and
        // rule writes. Frames are long, so results are rare, and the loop continues until
        // enough verdicts are planned.
        while (planned_items < ITEM_TARGET || planned_frames < MIN_VERDICTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                repeat ($urandom_range(1, 6)) plan_random_rule();
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    len = $urandom_range(54, 64);
                end else if (roll < 75) begin
                    len = $urandom_range(65, 90);
                end else if (roll < 95) begin
                    len = $urandom_range(1, 53);
                end else begin
                    len = 54;
                end
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    shape = SHAPE_CLEAN;
                end else if (roll < 77) begin
                    shape = SHAPE_BAD_ETYPE_HI;
                end else if (roll < 84) begin
                    shape = SHAPE_BAD_ETYPE_LO;
                end else if (roll < 92) begin
                    shape = SHAPE_NOT_TCP;
                end else begin
                    shape = SHAPE_NOISE;
                end
                plan_frame(len, shape, pick_port(), $urandom_range(0, 24) == 0, 40);
            end
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every item has been accepted and every expected verdict has arrived.
        // Then wait one more search time, so that a stray extra result would be seen.
        while (send_queue.size() != 0 || s_valid || verdicts_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (MAX_RULES + 16) @(posedge aclk);

        if (verdicts_due.size() != 0) begin
            $error("m_item: %0d expected verdicts never arrived", verdicts_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
